@@ rtl/dc_motor_hbridge_drive_with_tach_core_defines.svh @@
// Assertion macros shared by the motor channel RTL.
`ifndef DC_MOTOR_HBRIDGE_DRIVE_WITH_TACH_CORE_DEFINES_SVH
`define DC_MOTOR_HBRIDGE_DRIVE_WITH_TACH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clock and disabled during reset.
`define DMHB_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dmhb: assertion failed");
// Next-cycle implication, sampled on clock and disabled during reset.
`define DMHB_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dmhb: assertion failed");
`else
`define DMHB_ASSERT_IMP(lbl, ante, cons)
`define DMHB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/dmhb_pkg.sv @@
// Types, constants and codes shared by the motor channel modules.
package dmhb_pkg;

   // Field widths.
   localparam int KIND_W  = 2;
   localparam int SPEED_W = 16;
   localparam int TIME_W  = 32;
   localparam int DUTY_W  = 13;
   localparam int CNT_W   = 32;
   localparam int CPR_W   = 16;
   localparam int DB_W    = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 96;

   // Divider geometry: a 48-bit dividend and divisor, one quotient bit a step.
   localparam int DIV_W      = 48;
   localparam int DIV_STEP_W = $clog2(DIV_W);
   localparam logic [DIV_STEP_W-1:0] DIV_LAST = DIV_STEP_W'(DIV_W - 1);

   // Constants of the drive and the tachometer.
   localparam logic [CPR_W-1:0]  MS_PER_MINUTE = 16'd60000;
   localparam logic [DUTY_W-1:0] DUTY_IDLE     = 13'd4095;
   localparam logic [DUTY_W-1:0] DUTY_FULL     = 13'd4096;
   localparam logic [DUTY_W-1:0] DUTY_OFF      = 13'd0;
   localparam logic signed [16:0] SPEED_MAX    = 17'sd4095;
   localparam logic signed [16:0] SPEED_MIN    = -17'sd4095;
   localparam logic [DIV_W-1:0]  POS_LIMIT     = 48'h0000_7FFF_FFFF;
   localparam logic [DIV_W-1:0]  NEG_LIMIT     = 48'h0000_8000_0000;

   // Item kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_EDGE   = 2'd0,
      KIND_UPDATE = 2'd1,
      KIND_COAST  = 2'd2,
      KIND_BRAKE  = 2'd3
   } kind_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INVERT_MOTOR   = 2'd0,
      CSR_INVERT_ENCODER = 2'd1,
      CSR_COUNTS_PER_REV = 2'd2,
      CSR_DEAD_BAND      = 2'd3
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_MUL_NUM = 5'b00010,
      ST_MUL_DEN = 5'b00100,
      ST_DIV     = 5'b01000,
      ST_PUT     = 5'b10000
   } state_type;

   // Divider control and status.
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

@@ rtl/dmhb_div.sv @@
// Bit-serial restoring divider for the rpm quotient, one quotient bit per cycle.
`include "dc_motor_hbridge_drive_with_tach_core_defines.svh"

module dmhb_div (
   input  logic                          clock,
   input  logic                          reset,
   input  dmhb_pkg::div_ctl_type         ctl,
   input  logic [dmhb_pkg::DIV_W-1:0]    dividend,
   input  logic [dmhb_pkg::DIV_W-1:0]    divisor,
   output dmhb_pkg::div_sts_type         sts,
   output logic [dmhb_pkg::DIV_W-1:0]    quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [dmhb_pkg::DIV_STEP_W-1:0]   step_ff, step_in;
   logic [dmhb_pkg::DIV_W-1:0]        rem_ff, rem_in;
   logic [dmhb_pkg::DIV_W-1:0]        quo_ff, quo_in;
   logic [dmhb_pkg::DIV_W-1:0]        dsr_ff, dsr_in;
   logic [dmhb_pkg::DIV_W:0]          shifted;
   logic [dmhb_pkg::DIV_W:0]          diff;
   logic                              fits;

   // One trial subtraction of the divisor from the shifted partial remainder.
   assign shifted = {rem_ff, quo_ff[dmhb_pkg::DIV_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = ~diff[dmhb_pkg::DIV_W];

   // Step sequencing: load on start, then one quotient bit each cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[dmhb_pkg::DIV_W-1:0] : shifted[dmhb_pkg::DIV_W-1:0];
         quo_in  = {quo_ff[dmhb_pkg::DIV_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == dmhb_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

   // A start always begins a fresh run from the first step.
   `DMHB_ASSERT_NXT(a_div_start, ctl.start, busy_ff && step_ff == '0)
   // The finishing pulse comes only once the run has stopped.
   `DMHB_ASSERT_IMP(a_div_done_idle, done_ff, !busy_ff)
   // The partial remainder stays below the divisor during a run.
   `DMHB_ASSERT_IMP(a_div_rem_bound, busy_ff, rem_ff < dsr_ff)

endmodule

@@ rtl/dc_motor_hbridge_drive_with_tach_core.sv @@
// Motor channel top level: H-bridge duty drive, encoder position count and rpm meter.
//
// Items arrive on the req_ stream, with the item kind in req_tuser. An encoder
// edge item gives no result and leaves the block idle, so edge items can follow
// each other on every clock. Coast and brake items, and an update whose elapsed
// time or counts per revolution is zero, set the duties on the accepting edge;
// they then go through the output stage into the output register, which drives
// rsp_tvalid. Any other update also latches the count and time deltas on the
// accepting edge, then goes through a single shared 32x16 multiplier (count
// delta times 60000, then counts per revolution times elapsed ms), a bit-serial
// restoring divider, the divider's finishing pulse and the output stage. Most
// of an update's time is spent in the divider. The block takes no new item until
// the current one has been handed to the output register; that register lets the
// next item in while a result waits on rsp_tready, and a result that finds it
// still full waits in the output stage until rsp_tready frees it. Configuration
// writes are taken at any time and should be made only while the block is idle.
`include "dc_motor_hbridge_drive_with_tach_core_defines.svh"

module dc_motor_hbridge_drive_with_tach_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input items.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // enc_a_level [0], enc_b_level [1], raw_speed [17:2], now_ms [49:18], zeros
   input  logic [dmhb_pkg::REQ_DATA_W-1:0]      req_tdata,
   // kind [1:0]
   input  logic [dmhb_pkg::KIND_W-1:0]          req_tuser,
   // Result items.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // duty_a [12:0], duty_b [25:13], speed_rpm [57:26], position_count [89:58], zeros
   output logic [dmhb_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Configuration writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dmhb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dmhb_pkg::CSR_DATA_W-1:0]      csr_data
);

   // Configuration registers.
   logic                              inv_motor_ff, inv_motor_in;
   logic                              inv_enc_ff, inv_enc_in;
   logic [dmhb_pkg::CPR_W-1:0]        cpr_ff, cpr_in;
   logic [dmhb_pkg::DB_W-1:0]         db_ff, db_in;

   // Channel state.
   dmhb_pkg::state_type               state_ff, state_in;
   logic [dmhb_pkg::CNT_W-1:0]        count_now_ff, count_now_in;
   logic [dmhb_pkg::CNT_W-1:0]        count_prev_ff, count_prev_in;
   logic [dmhb_pkg::TIME_W-1:0]       time_prev_ff, time_prev_in;
   logic [dmhb_pkg::CNT_W-1:0]        rpm_ff, rpm_in;

   // Working registers of one update.
   logic                              neg_ff, neg_in;
   logic [dmhb_pkg::CNT_W-1:0]        mag_ff, mag_in;
   logic [dmhb_pkg::TIME_W-1:0]       dtime_ff, dtime_in;
   logic [dmhb_pkg::DIV_W-1:0]        num_ff, num_in;
   logic [dmhb_pkg::DUTY_W-1:0]       duty_a_ff, duty_a_in;
   logic [dmhb_pkg::DUTY_W-1:0]       duty_b_ff, duty_b_in;

   // Output register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [dmhb_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // Input fields.
   dmhb_pkg::kind_type                kind;
   logic                              enc_a;
   logic                              enc_b;
   logic signed [dmhb_pkg::SPEED_W-1:0] raw_speed;
   logic [dmhb_pkg::TIME_W-1:0]       now_ms;
   logic                              req_fire;
   logic                              slot_free;

   // Combinational helpers.
   logic signed [16:0]                spd_ext;
   logic signed [16:0]                spd_clamp;
   logic signed [16:0]                db_pos;
   logic signed [16:0]                db_neg;
   logic [dmhb_pkg::DUTY_W-1:0]       upd_duty_a;
   logic [dmhb_pkg::DUTY_W-1:0]       upd_duty_b;
   logic [dmhb_pkg::CNT_W-1:0]        dcount;
   logic [dmhb_pkg::TIME_W-1:0]       dtime;
   logic [dmhb_pkg::CNT_W-1:0]        mul_a;
   logic [dmhb_pkg::CPR_W-1:0]        mul_b;
   logic [dmhb_pkg::DIV_W-1:0]        product;
   logic [dmhb_pkg::CNT_W-1:0]        sat_mag;
   logic [dmhb_pkg::CNT_W-1:0]        rpm_new;

   // Divider interface.
   dmhb_pkg::div_ctl_type             div_ctl;
   dmhb_pkg::div_sts_type             div_sts;
   logic [dmhb_pkg::DIV_W-1:0]        quotient;

   // Field unpacking and handshakes.
   assign kind      = dmhb_pkg::kind_type'(req_tuser);
   assign enc_a     = req_tdata[0];
   assign enc_b     = req_tdata[1];
   assign raw_speed = req_tdata[17:2];
   assign now_ms    = req_tdata[49:18];
   assign req_tready = (state_ff == dmhb_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Speed command: sign-extend, optionally negate, clamp, then pick the duties.
   always_comb begin
      spd_ext = 17'(raw_speed);
      if (inv_motor_ff) begin
         spd_ext = -spd_ext;
      end
      if (spd_ext > dmhb_pkg::SPEED_MAX) begin
         spd_clamp = dmhb_pkg::SPEED_MAX;
      end else if (spd_ext < dmhb_pkg::SPEED_MIN) begin
         spd_clamp = dmhb_pkg::SPEED_MIN;
      end else begin
         spd_clamp = spd_ext;
      end
      db_pos = signed'({5'd0, db_ff});
      db_neg = -db_pos;
      if (spd_clamp > db_pos) begin
         upd_duty_a = spd_clamp[dmhb_pkg::DUTY_W-1:0];
         upd_duty_b = dmhb_pkg::DUTY_OFF;
      end else if (spd_clamp < db_neg) begin
         upd_duty_a = dmhb_pkg::DUTY_OFF;
         upd_duty_b = 13'(-spd_clamp);
      end else begin
         upd_duty_a = dmhb_pkg::DUTY_IDLE;
         upd_duty_b = dmhb_pkg::DUTY_IDLE;
      end
   end

   // Deltas since the previous update.
   assign dcount = count_now_ff - count_prev_ff;
   assign dtime  = now_ms - time_prev_ff;

   // Shared multiplier: count magnitude times 60000, then cpr times elapsed ms.
   assign mul_a   = (state_ff == dmhb_pkg::ST_MUL_NUM) ? mag_ff : dtime_ff;
   assign mul_b   = (state_ff == dmhb_pkg::ST_MUL_NUM) ? dmhb_pkg::MS_PER_MINUTE : cpr_ff;
   assign product = dmhb_pkg::DIV_W'(mul_a) * dmhb_pkg::DIV_W'(mul_b);

   // The divider takes the numerator register and the fresh denominator product.
   assign div_ctl.start = (state_ff == dmhb_pkg::ST_MUL_DEN);

   dmhb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (num_ff),
      .divisor  (product),
      .sts      (div_sts),
      .quotient (quotient)
   );

   // Saturate the quotient to the signed 32-bit range and restore the sign.
   always_comb begin
      if (neg_ff) begin
         sat_mag = (quotient > dmhb_pkg::NEG_LIMIT) ? dmhb_pkg::NEG_LIMIT[31:0]
                                                    : quotient[31:0];
         rpm_new = -sat_mag;
      end else begin
         sat_mag = (quotient > dmhb_pkg::POS_LIMIT) ? dmhb_pkg::POS_LIMIT[31:0]
                                                    : quotient[31:0];
         rpm_new = sat_mag;
      end
   end

   // Configuration writes.
   always_comb begin
      inv_motor_in = inv_motor_ff;
      inv_enc_in   = inv_enc_ff;
      cpr_in       = cpr_ff;
      db_in        = db_ff;
      if (csr_valid && csr_ready) begin
         case (dmhb_pkg::csr_index_type'(csr_index))
            dmhb_pkg::CSR_INVERT_MOTOR:   inv_motor_in = csr_data[0];
            dmhb_pkg::CSR_INVERT_ENCODER: inv_enc_in   = csr_data[0];
            dmhb_pkg::CSR_COUNTS_PER_REV: cpr_in       = csr_data;
            dmhb_pkg::CSR_DEAD_BAND:      db_in        = csr_data[dmhb_pkg::DB_W-1:0];
            default:                      db_in        = db_ff;
         endcase
      end
   end

   // Sequencer and channel state.
   always_comb begin
      state_in      = state_ff;
      count_now_in  = count_now_ff;
      count_prev_in = count_prev_ff;
      time_prev_in  = time_prev_ff;
      rpm_in        = rpm_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      dtime_in      = dtime_ff;
      num_in        = num_ff;
      duty_a_in     = duty_a_ff;
      duty_b_in     = duty_b_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         dmhb_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (kind)
                  dmhb_pkg::KIND_EDGE: begin
                     // Unequal levels count up; the invert flag swaps directions.
                     if ((enc_a != enc_b) != inv_enc_ff) begin
                        count_now_in = count_now_ff + 1'b1;
                     end else begin
                        count_now_in = count_now_ff - 1'b1;
                     end
                  end
                  dmhb_pkg::KIND_UPDATE: begin
                     duty_a_in     = upd_duty_a;
                     duty_b_in     = upd_duty_b;
                     neg_in        = dcount[dmhb_pkg::CNT_W-1];
                     mag_in        = dcount[dmhb_pkg::CNT_W-1] ? -dcount : dcount;
                     dtime_in      = dtime;
                     count_prev_in = count_now_ff;
                     time_prev_in  = now_ms;
                     if (dtime == '0 || cpr_ff == '0) begin
                        state_in = dmhb_pkg::ST_PUT;
                     end else begin
                        state_in = dmhb_pkg::ST_MUL_NUM;
                     end
                  end
                  dmhb_pkg::KIND_COAST: begin
                     duty_a_in = dmhb_pkg::DUTY_OFF;
                     duty_b_in = dmhb_pkg::DUTY_OFF;
                     state_in  = dmhb_pkg::ST_PUT;
                  end
                  default: begin
                     duty_a_in = dmhb_pkg::DUTY_FULL;
                     duty_b_in = dmhb_pkg::DUTY_FULL;
                     state_in  = dmhb_pkg::ST_PUT;
                  end
               endcase
            end
         end
         dmhb_pkg::ST_MUL_NUM: begin
            num_in   = product;
            state_in = dmhb_pkg::ST_MUL_DEN;
         end
         dmhb_pkg::ST_MUL_DEN: begin
            state_in = dmhb_pkg::ST_DIV;
         end
         dmhb_pkg::ST_DIV: begin
            if (div_sts.done) begin
               rpm_in   = rpm_new;
               state_in = dmhb_pkg::ST_PUT;
            end
         end
         dmhb_pkg::ST_PUT: begin
            // Hand the result over once the output register is free.
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, count_now_ff, rpm_ff, duty_b_ff, duty_a_ff};
               state_in     = dmhb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dmhb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dmhb_pkg::ST_IDLE;
         inv_motor_ff  <= 1'b0;
         inv_enc_ff    <= 1'b0;
         cpr_ff        <= dmhb_pkg::CPR_W'(1);
         db_ff         <= '0;
         count_now_ff  <= '0;
         count_prev_ff <= '0;
         time_prev_ff  <= '0;
         rpm_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         inv_motor_ff  <= inv_motor_in;
         inv_enc_ff    <= inv_enc_in;
         cpr_ff        <= cpr_in;
         db_ff         <= db_in;
         count_now_ff  <= count_now_in;
         count_prev_ff <= count_prev_in;
         time_prev_ff  <= time_prev_in;
         rpm_ff        <= rpm_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      dtime_ff    <= dtime_in;
      num_ff      <= num_in;
      duty_a_ff   <= duty_a_in;
      duty_b_ff   <= duty_b_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An encoder edge leaves the block ready for the next item.
   `DMHB_ASSERT_NXT(a_edge_ready, req_fire && kind == dmhb_pkg::KIND_EDGE, req_tready)
   // An update with no elapsed time keeps the held rpm.
   `DMHB_ASSERT_NXT(a_rpm_hold, req_fire && kind == dmhb_pkg::KIND_UPDATE && dtime == '0, rpm_ff == $past(rpm_ff))
   // Leaving the output stage always presents a result.
   `DMHB_ASSERT_NXT(a_put_shows, state_ff == dmhb_pkg::ST_PUT && slot_free, rsp_valid_ff)
   // The divider keeps running for as long as the sequencer waits on it.
   `DMHB_ASSERT_IMP(a_div_busy, state_ff == dmhb_pkg::ST_DIV && !div_sts.done, div_sts.busy)

endmodule
